FILE: rtl/wzh_pkg.sv
// Shared constants and types for the window stack hit test block.
`timescale 1ns / 1ps

package wzh_pkg;

  // Field widths of the request and response transactions
  localparam int CMD_W    = 2;
  localparam int FIELD_W  = 12;
  localparam int NUMBER_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Search token handed from cell to cell
  typedef struct packed {
    logic active;
    logic found;
  } tok_t;

  // Update controls broadcast to every cell
  typedef struct packed {
    logic shift;   // load: every cell takes its upper neighbor
    logic commit;  // move to front: marked cells take their upper neighbor
  } cell_ctl_t;

endpackage

FILE: rtl/wzh_req_if.sv
// Request channel: command and coordinates with valid/ready handshake.
`timescale 1ns / 1ps

interface wzh_req_if;
  import wzh_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FIELD_W-1:0] pos_x;
  logic [FIELD_W-1:0] pos_y;
  logic [FIELD_W-1:0] far_x;
  logic [FIELD_W-1:0] far_y;

  modport source (output valid, cmd, pos_x, pos_y, far_x, far_y, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, far_x, far_y, output ready);
endinterface

FILE: rtl/wzh_rsp_if.sv
// Response channel: clicked window number and hit flag with valid/ready handshake.
`timescale 1ns / 1ps

interface wzh_rsp_if;
  import wzh_pkg::*;

  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] window_number;
  logic                hit;

  modport source (output valid, window_number, hit, input ready);
  modport sink   (input valid, window_number, hit, output ready);
endinterface

FILE: rtl/wzh_cell.sv
// One stack position: holds a window, tests the click point, passes the token on.
`timescale 1ns / 1ps

module wzh_cell #(
  parameter int IDX         = 0,
  parameter int COORD_BITS  = 12,
  parameter int NUM_BITS    = 5,
  parameter int WIN_W       = NUM_BITS + 4 * COORD_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wzh_pkg::cell_ctl_t    ctl,
  input  logic [NUM_BITS-1:0]   count,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic [WIN_W-1:0]      prev_win,
  input  wzh_pkg::tok_t         tok_in,
  input  logic [WIN_W-1:0]      tok_win_in,
  output logic [WIN_W-1:0]      win,
  output wzh_pkg::tok_t         tok_out,
  output logic [WIN_W-1:0]      tok_win_out
);
  import wzh_pkg::*;

  localparam int TOP_LO    = 0;
  localparam int RIGHT_LO  = COORD_BITS;
  localparam int BOTTOM_LO = 2 * COORD_BITS;
  localparam int LEFT_LO   = 3 * COORD_BITS;

  logic                  mv;
  logic                  in_use;
  logic                  hit;
  logic [COORD_BITS-1:0] left_e, bottom_e, right_e, top_e;

  assign top_e    = win[TOP_LO    +: COORD_BITS];
  assign right_e  = win[RIGHT_LO  +: COORD_BITS];
  assign bottom_e = win[BOTTOM_LO +: COORD_BITS];
  assign left_e   = win[LEFT_LO   +: COORD_BITS];

  assign in_use = count > NUM_BITS'(IDX);
  assign hit    = in_use && point_x >= left_e && point_x <= right_e &&
                  point_y >= bottom_e && point_y <= top_e;

  // Window storage: shift down on load, or on move to front when marked
  always_ff @(posedge clk) begin
    if (ctl.shift || (ctl.commit && mv)) begin
      win <= prev_win;
    end
  end

  // Mark cells at or above the hit so they make room at the top
  always_ff @(posedge clk) begin
    if (rst) begin
      mv      <= 1'b0;
      tok_out <= '0;
    end else begin
      if (tok_in.active) begin
        mv <= !tok_in.found;
      end
      tok_out.active <= tok_in.active;
      tok_out.found  <= tok_in.found | hit;
    end
  end

  // Carry the first hit window along with the token
  always_ff @(posedge clk) begin
    tok_win_out <= tok_in.found ? tok_win_in : win;
  end

endmodule

FILE: rtl/window_zorder_hit_test.sv
// Top level: window stack hit test with move to front over a chain of cells.
// Timing: add and clear take effect in the cycle after acceptance; a click result
//   passes the start flag, each cell's token register, the capture register and
//   the output register. No request is taken until a click result leaves; the search
//   token walks one cell per cycle. Add and clear are taken every cycle while idle.
// Reset: synchronous, clears window count, handshake state and cell tokens, not windows.
`timescale 1ns / 1ps

module window_zorder_hit_test #(
  parameter int MAX_WINDOWS = 16,
  parameter int COORD_BITS  = 12
) (
  input  logic          clk,
  input  logic          rst,
  wzh_req_if.sink       req,
  wzh_rsp_if.source     rsp
);
  import wzh_pkg::*;

  // Window numbers run 1..MAX_WINDOWS; the count needs to hold MAX_WINDOWS itself
  localparam int NUM_BITS = $clog2(MAX_WINDOWS + 1);
  localparam int WIN_W    = NUM_BITS + 4 * COORD_BITS;
  localparam int NUM_LO   = 4 * COORD_BITS;

  // Sequencer codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]            state, state_next;
  logic [NUM_BITS-1:0]   count, count_next;
  logic [COORD_BITS-1:0] point_x, point_y;
  logic                  start;
  logic                  fin_found;
  logic [WIN_W-1:0]      fin_win;
  logic                  rsp_valid;
  logic [NUMBER_W-1:0]   rsp_number;
  logic                  rsp_hit;

  logic [COORD_BITS-1:0] in_x, in_y, in_fx, in_fy;
  logic [NUMBER_W-1:0]   fin_number;
  logic                  accept, do_load, do_click, do_clear, fin_fire;
  logic [WIN_W-1:0]      new_win, head_win;
  cell_ctl_t             ctl;

  logic [WIN_W-1:0]      win     [MAX_WINDOWS];
  tok_t                  tok     [MAX_WINDOWS];
  logic [WIN_W-1:0]      tok_win [MAX_WINDOWS];

  // Take coordinates in their low COORD_BITS bits, widen if the store is wider
  generate
    if (COORD_BITS <= FIELD_W) begin : g_coord_cut
      assign in_x  = req.pos_x[COORD_BITS-1:0];
      assign in_y  = req.pos_y[COORD_BITS-1:0];
      assign in_fx = req.far_x[COORD_BITS-1:0];
      assign in_fy = req.far_y[COORD_BITS-1:0];
    end else begin : g_coord_ext
      assign in_x  = {{(COORD_BITS-FIELD_W){1'b0}}, req.pos_x};
      assign in_y  = {{(COORD_BITS-FIELD_W){1'b0}}, req.pos_y};
      assign in_fx = {{(COORD_BITS-FIELD_W){1'b0}}, req.far_x};
      assign in_fy = {{(COORD_BITS-FIELD_W){1'b0}}, req.far_y};
    end
  endgenerate

  // Fit the stored window number to the response field
  generate
    if (NUM_BITS >= NUMBER_W) begin : g_num_cut
      assign fin_number = fin_win[NUM_LO +: NUMBER_W];
    end else begin : g_num_ext
      assign fin_number = {{(NUMBER_W-NUM_BITS){1'b0}}, fin_win[NUM_LO +: NUM_BITS]};
    end
  endgenerate

  // Requests are taken only between clicks and out of reset
  assign req.ready = (state == ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;

  // Decode the accepted transaction; unknown codes are dropped
  always_comb begin
    do_load  = 1'b0;
    do_click = 1'b0;
    do_clear = 1'b0;
    unique case (req.cmd)
      CMD_ADD:   do_load  = accept && (count < NUM_BITS'(MAX_WINDOWS));
      CMD_CLICK: do_click = accept;
      CMD_CLEAR: do_clear = accept;
      default:   ;
    endcase
  end

  // Result leaves once the output register is free
  assign fin_fire = (state == ST_FIN) && (!rsp_valid || rsp.ready);

  // A load pushes the new window in at the top; a hit puts the found window back on top
  assign new_win    = {count + NUM_BITS'(1), in_x, in_y, in_fx, in_fy};
  assign head_win   = do_load ? new_win : fin_win;
  assign ctl.shift  = do_load;
  assign ctl.commit = fin_fire && fin_found;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (do_click) state_next = ST_SCAN;
      ST_SCAN: if (tok[MAX_WINDOWS-1].active) state_next = ST_FIN;
      ST_FIN:  if (fin_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_clear) begin
      count_next = '0;
    end else if (do_load) begin
      count_next = count + NUM_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      start     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      start <= do_click;
      // Hold the response until the sink takes the transaction
      if (fin_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Latch the click point for the whole search
  always_ff @(posedge clk) begin
    if (do_click) begin
      point_x <= in_x;
      point_y <= in_y;
    end
  end

  // Capture the token as it drops off the bottom of the chain
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tok[MAX_WINDOWS-1].active) begin
      fin_found <= tok[MAX_WINDOWS-1].found;
      fin_win   <= tok_win[MAX_WINDOWS-1];
    end
  end

  // Load the response payload; a miss reports window number zero
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      rsp_number <= fin_found ? fin_number : '0;
      rsp_hit    <= fin_found;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.window_number = rsp_number;
  assign rsp.hit           = rsp_hit;

  // Cell chain: position 0 is the top of the stack
  generate
    for (genvar k = 0; k < MAX_WINDOWS; k++) begin : g_cell
      tok_t             tok_src;
      logic [WIN_W-1:0] win_src;
      logic [WIN_W-1:0] tok_win_src;

      if (k == 0) begin : g_head
        assign tok_src     = '{active: start, found: 1'b0};
        assign win_src     = head_win;
        assign tok_win_src = head_win;
      end else begin : g_body
        assign tok_src     = tok[k-1];
        assign win_src     = win[k-1];
        assign tok_win_src = tok_win[k-1];
      end

      wzh_cell #(
        .IDX        (k),
        .COORD_BITS (COORD_BITS),
        .NUM_BITS   (NUM_BITS),
        .WIN_W      (WIN_W)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .count       (count),
        .point_x     (point_x),
        .point_y     (point_y),
        .prev_win    (win_src),
        .tok_in      (tok_src),
        .tok_win_in  (tok_win_src),
        .win         (win[k]),
        .tok_out     (tok[k]),
        .tok_win_out (tok_win[k])
      );
    end
  endgenerate

`ifndef SYNTH
  // The stack never holds more windows than there are cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NUM_BITS'(MAX_WINDOWS))
    else $error("window count past capacity");

  // An accepted load with room adds exactly one window
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    do_load |=> count == $past(count) + NUM_BITS'(1))
    else $error("load did not advance window count");

  // Move to front happens only when a result is handed off
  a_commit_fin: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (state == ST_FIN) && !ctl.shift)
    else $error("commit outside result handoff");

  // A hit always names a real window
  a_hit_number: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hit) |-> rsp.window_number != '0)
    else $error("hit reported with window number zero");
`endif

endmodule
